### rtl/u16b64_pkg.sv
// Shared types, constants and base64 helpers for the UTF-16LE base64 encoder.
// No dependencies; used by the top level, the encoder and the result buffer.
package u16b64_pkg;

	localparam int TextW     = 8;                 // input character width
	localparam int CodeW     = 7;                 // output ASCII character width
	localparam int MaxChars  = 8;                 // most characters one item can yield
	localparam int NumW      = $clog2(MaxChars + 1);
	localparam int IdxW      = $clog2(MaxChars);

	localparam logic [TextW-1:0] SubstChar = 8'h3F;   // '?' for high characters
	localparam logic [CodeW-1:0] PadChar   = 7'h3D;   // '='

	typedef logic [CodeW-1:0] code_t;

	// Result of encoding one input item: up to eight characters
	typedef struct packed {
		code_t [MaxChars-1:0] chars;   // element 0 goes out first
		logic  [NumW-1:0]     num;     // valid characters, 0 to 8
		logic                 last;    // final character closes the text
	} enc_res_t;

	// Standard base64 alphabet
	function automatic code_t b64_char(input logic [5:0] v);
		code_t c;
		if (v < 6'd26) begin
			c = 7'h41 + code_t'(v);
		end else if (v < 6'd52) begin
			c = 7'h61 + code_t'(v - 6'd26);
		end else if (v < 6'd62) begin
			c = 7'h30 + code_t'(v - 6'd52);
		end else if (v == 6'd62) begin
			c = 7'h2B;
		end else begin
			c = 7'h2F;
		end
		return c;
	endfunction

	// Three bytes to four characters; element 0 from the top sextet
	function automatic code_t [3:0] b64_group(input logic [23:0] g);
		code_t [3:0] q;
		q[0] = b64_char(g[23:18]);
		q[1] = b64_char(g[17:12]);
		q[2] = b64_char(g[11:6]);
		q[3] = b64_char(g[5:0]);
		return q;
	endfunction

endpackage

### rtl/utf16le_base64_encoder_core.sv
// Top level of the UTF-16LE base64 encoder: input register, byte state, encoder, buffer.
// Depends on u16b64_pkg, u16b64_enc and u16b64_ser.
//
//  channel  | dir | tdata               | tuser | tlast
//  s_axis   | in  | [7:0] text_char     | -     | text_last
//  m_axis   | out | [6:0] code_char     | -     | code_last
//
// An item is encoded in the cycle it moves from the input register into the
// result buffer; it yields 0, 4 or 8 characters, sent one word per cycle
// while the output port accepts them.
// Items yielding nothing pass at one per cycle while the result buffer is empty.
// The input register takes a new item while the buffer still holds results, if it is empty itself.
// arst_n clears the waiting-byte state and both valid flags.
module utf16le_base64_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,    // [7:0] text_char
	input  logic       s_axis_tlast,    // text_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,    // [6:0] code_char, [7] zero
	output logic       m_axis_tlast     // code_last
);

	logic                          vld_s1;
	logic [u16b64_pkg::TextW-1:0]  char_s1;
	logic                          last_s1;
	logic [15:0]                   pend_q;
	logic [1:0]                    cnt_q;
	logic [15:0]                   nxt_pend;
	logic [1:0]                    nxt_cnt;
	u16b64_pkg::enc_res_t          res;
	logic                          load_ok;
	logic                          load;

	assign load          = vld_s1 && load_ok;
	assign s_axis_tready = !vld_s1 || load_ok;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Waiting bytes between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			pend_q <= nxt_pend;
			cnt_q  <= nxt_cnt;
		end
	end

	u16b64_enc u_enc (
		.text_char (char_s1),
		.text_last (last_s1),
		.pend      (pend_q),
		.cnt       (cnt_q),
		.nxt_pend  (nxt_pend),
		.nxt_cnt   (nxt_cnt),
		.res       (res)
	);

	u16b64_ser u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.res           (res),
		.load_ok       (load_ok),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### rtl/u16b64_enc.sv
// Combinational encode step: widens one character, groups bytes, emits characters.
// Depends on u16b64_pkg.
module u16b64_enc (
	input  logic [u16b64_pkg::TextW-1:0] text_char,
	input  logic                         text_last,
	input  logic [15:0]                  pend,       // waiting bytes, first in [15:8]
	input  logic [1:0]                   cnt,        // waiting byte count
	output logic [15:0]                  nxt_pend,
	output logic [1:0]                   nxt_cnt,
	output u16b64_pkg::enc_res_t         res
);

	logic [7:0]                   ch;
	u16b64_pkg::code_t [3:0]      q_main;
	u16b64_pkg::code_t [3:0]      q_tail;

	// Characters at 0x80 and above become '?'
	assign ch = text_char[7] ? u16b64_pkg::SubstChar : text_char;

	// Each item pushes the character byte and then a zero high byte
	always_comb begin
		res      = '0;
		nxt_pend = pend;
		nxt_cnt  = cnt;
		q_main   = u16b64_pkg::b64_group(24'h0);
		q_tail   = u16b64_pkg::b64_group(24'h0);
		case (cnt)
			2'd0: begin
				// both bytes wait; on last flush with one pad
				nxt_pend = {ch, 8'h00};
				nxt_cnt  = 2'd2;
				if (text_last) begin
					q_main       = u16b64_pkg::b64_group({ch, 16'h0000});
					res.chars[0] = q_main[0];
					res.chars[1] = q_main[1];
					res.chars[2] = q_main[2];
					res.chars[3] = u16b64_pkg::PadChar;
					res.num      = u16b64_pkg::NumW'(4);
				end
			end
			2'd1: begin
				// waiting byte, character and zero byte close a group; nothing waits
				q_main       = u16b64_pkg::b64_group({pend[15:8], ch, 8'h00});
				res.chars[0] = q_main[0];
				res.chars[1] = q_main[1];
				res.chars[2] = q_main[2];
				res.chars[3] = q_main[3];
				res.num      = u16b64_pkg::NumW'(4);
				nxt_pend     = 16'h0000;
				nxt_cnt      = 2'd0;
			end
			2'd2: begin
				// character closes a group, zero byte waits alone
				q_main       = u16b64_pkg::b64_group({pend, ch});
				res.chars[0] = q_main[0];
				res.chars[1] = q_main[1];
				res.chars[2] = q_main[2];
				res.chars[3] = q_main[3];
				res.num      = u16b64_pkg::NumW'(4);
				nxt_pend     = 16'h0000;
				nxt_cnt      = 2'd1;
				if (text_last) begin
					q_tail       = u16b64_pkg::b64_group(24'h000000);
					res.chars[4] = q_tail[0];
					res.chars[5] = q_tail[1];
					res.chars[6] = u16b64_pkg::PadChar;
					res.chars[7] = u16b64_pkg::PadChar;
					res.num      = u16b64_pkg::NumW'(8);
				end
			end
			default: begin
				nxt_pend = 16'h0000;
				nxt_cnt  = 2'd0;
			end
		endcase
		// end of text: flag the final character and start over
		if (text_last) begin
			res.last = 1'b1;
			nxt_pend = 16'h0000;
			nxt_cnt  = 2'd0;
		end
	end

endmodule

### rtl/u16b64_ser.sv
// Result buffer: holds up to eight characters of one item and sends one per word.
// Depends on u16b64_pkg.
module u16b64_ser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  u16b64_pkg::enc_res_t         res,
	output logic                         load_ok,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [7:0]                   m_axis_tdata,   // [6:0] code_char, [7] zero
	output logic                         m_axis_tlast    // code_last
);

	u16b64_pkg::code_t [u16b64_pkg::MaxChars-1:0] buf_q;
	logic [u16b64_pkg::NumW-1:0]                  num_q;
	logic [u16b64_pkg::IdxW-1:0]                  idx_q;
	logic                                         last_q;
	logic                                         final_word;
	logic                                         take;

	assign final_word = (u16b64_pkg::NumW'(idx_q) + u16b64_pkg::NumW'(1)) == num_q;
	assign take       = m_axis_tvalid && m_axis_tready;
	// free now, or the last waiting word leaves this cycle
	assign load_ok    = (num_q == '0) || (take && final_word);

	// Buffer payload
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res.chars;
		end
	end

	// Read position and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			idx_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			num_q  <= res.num;
			idx_q  <= '0;
			last_q <= res.last;
		end else if (take) begin
			if (final_word) begin
				num_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + u16b64_pkg::IdxW'(1);
			end
		end
	end

	assign m_axis_tvalid = num_q != '0;
	assign m_axis_tdata  = {1'b0, buf_q[idx_q]};
	assign m_axis_tlast  = last_q && final_word;

endmodule

### rtl/u16b64_chk.sv
// Port-level checks for the UTF-16LE base64 encoder, bound to the top level.
// Depends on the ports of utf16le_base64_encoder_core only.
module u16b64_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	// stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// every word is a base64 character or padding
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h5A)
			|| (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h7A)
			|| (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39)
			|| m_axis_tdata == 8'h2B || m_axis_tdata == 8'h2F || m_axis_tdata == 8'h3D)
		else $error("illegal output character");

	// input only stalls behind a waiting result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	// a non-final padding word that leaves is followed by a final padding word
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tdata == 8'h3D && !m_axis_tlast
			|=> m_axis_tvalid && m_axis_tdata == 8'h3D && m_axis_tlast)
		else $error("broken padding sequence");

endmodule

bind utf16le_base64_encoder_core u16b64_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
